// File: rtl/core/twhbt_pkg.sv
// ----------------------------------------------------------------------------
// twhbt_pkg
// shared types and constants for the two-wire handshake byte engine
// ----------------------------------------------------------------------------
`default_nettype none

package twhbt_pkg;

    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_WRITE  = 2'd2;

    localparam logic [3:0] READ_STEPS  = 4'd10;
    localparam logic [3:0] WRITE_STEPS = 4'd8;
    localparam logic [3:0] LAST_SAMPLE = 4'd8;
    localparam logic [7:0] SAMPLE_BIT  = 8'h80;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_READ,
        OP_WRITE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] write_byte;
        logic       clock_in;
        logic       data_in;
    } item_t;

    typedef struct packed {
        logic       busy_res;
        logic       byte_done;
        logic [7:0] read_result;
        logic       data_out;
        logic       atn_out;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/twhbt_front.sv
// ----------------------------------------------------------------------------
// twhbt_front
// accepts input transfers, classifies the request kind and registers the item
// ----------------------------------------------------------------------------
`default_nettype none

module twhbt_front (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [twhbt_pkg::IN_DATA_W-1:0]     s_tdata,
    input  wire logic [twhbt_pkg::IN_USER_W-1:0]     s_tuser,
    output logic                                     item_valid,
    output twhbt_pkg::item_t                         item,
    input  wire logic                                item_ready
);
    import twhbt_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;
    op_t   op_cls;

    always_comb begin
        unique case (s_tuser)
            KIND_READ:  op_cls = OP_READ;
            KIND_WRITE: op_cls = OP_WRITE;
            default:    op_cls = OP_SAMPLE;
        endcase
        item_next.op         = op_cls;
        item_next.write_byte = s_tdata[7:0];
        item_next.clock_in   = s_tdata[8];
        item_next.data_in    = s_tdata[9];
    end

    assign s_tready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/twhbt_queue.sv
// ----------------------------------------------------------------------------
// twhbt_queue
// two-entry queue between the classifying front and the line engine
// ----------------------------------------------------------------------------
`default_nettype none

module twhbt_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_valid,
    input  wire twhbt_pkg::item_t  push_item,
    output logic                   push_ready,
    output logic                   pop_valid,
    output twhbt_pkg::item_t       pop_item,
    input  wire logic              pop_ready
);
    import twhbt_pkg::*;

    item_t      mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            priority if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end else begin
                count_reg <= count_reg;
            end
        end
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/twhbt_back.sv
// ----------------------------------------------------------------------------
// twhbt_back
// handshake engine: steps the half-steps, drives the lines, holds the result
// ----------------------------------------------------------------------------
`default_nettype none

module twhbt_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              item_valid,
    input  wire twhbt_pkg::item_t                  item,
    output logic                                   item_ready,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [twhbt_pkg::OUT_DATA_W-1:0]       m_tdata
);
    import twhbt_pkg::*;

    logic [3:0] half_step_reg, half_step_next;
    logic [7:0] shift_reg, shift_next;
    logic       is_write_reg, is_write_next;
    logic       active_reg, active_next;
    logic       atn_level_reg, atn_level_next;
    logic       data_level_reg, data_level_next;
    logic       m_valid_reg;
    result_t    res_reg, res_next;
    logic [3:0] step_inc;
    logic [7:0] result_val;
    logic       done_val;
    logic       pop;

    assign item_ready = !m_valid_reg || m_tready;
    assign pop        = item_valid && item_ready;
    assign step_inc   = half_step_reg + 4'd1;

    always_comb begin
        half_step_next  = half_step_reg;
        shift_next      = shift_reg;
        is_write_next   = is_write_reg;
        active_next     = active_reg;
        atn_level_next  = atn_level_reg;
        data_level_next = data_level_reg;
        result_val      = 8'd0;
        done_val        = 1'b0;
        if (active_reg) begin
            if (item.clock_in == half_step_reg[0]) begin
                half_step_next = step_inc;
                if (!is_write_reg) begin
                    if (step_inc <= LAST_SAMPLE) begin
                        shift_next = (shift_reg >> 1) | (item.data_in ? SAMPLE_BIT : 8'd0);
                    end
                    if (step_inc >= READ_STEPS) begin
                        active_next    = 1'b0;
                        done_val       = 1'b1;
                        result_val     = shift_reg;
                        atn_level_next = 1'b1;
                    end else begin
                        atn_level_next = step_inc[0];
                    end
                end else begin
                    if (step_inc >= WRITE_STEPS) begin
                        active_next     = 1'b0;
                        done_val        = 1'b1;
                        data_level_next = 1'b0;
                        atn_level_next  = 1'b1;
                    end else begin
                        data_level_next = shift_reg[0];
                        shift_next      = shift_reg >> 1;
                        atn_level_next  = step_inc[0];
                    end
                end
            end
        end else begin
            unique case (item.op)
                OP_READ: begin
                    active_next    = 1'b1;
                    is_write_next  = 1'b0;
                    half_step_next = 4'd0;
                    shift_next     = 8'd0;
                    atn_level_next = 1'b0;
                end
                OP_WRITE: begin
                    active_next     = 1'b1;
                    is_write_next   = 1'b1;
                    half_step_next  = 4'd0;
                    data_level_next = item.write_byte[0];
                    shift_next      = item.write_byte >> 1;
                    atn_level_next  = 1'b0;
                end
                default: begin
                end
            endcase
        end
        res_next.atn_out     = atn_level_next;
        res_next.data_out    = data_level_next;
        res_next.read_result = result_val;
        res_next.byte_done   = done_val;
        res_next.busy_res    = active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_step_reg  <= 4'd0;
            shift_reg      <= 8'd0;
            is_write_reg   <= 1'b0;
            active_reg     <= 1'b0;
            atn_level_reg  <= 1'b1;
            data_level_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (pop) begin
                half_step_reg  <= half_step_next;
                shift_reg      <= shift_next;
                is_write_reg   <= is_write_next;
                active_reg     <= active_next;
                atn_level_reg  <= atn_level_next;
                data_level_reg <= data_level_next;
            end
            if (item_ready) begin
                m_valid_reg <= item_valid;
            end
        end
        if (pop) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, res_reg};

endmodule

`default_nettype wire

// File: rtl/core/two_wire_handshake_byte_transfer_top.sv
// path: an input passes through the front item register, a queue entry and the engine result register
// throughput: one item per cycle while the result channel is not stalled by m_tready
// every input transfer gives exactly one result transfer
// reset: synchronous, active low; engine idle, attention asserted, data released
// ----------------------------------------------------------------------------
// two_wire_handshake_byte_transfer_top
// host-side byte engine for a two-wire attention/clock handshake link
// ----------------------------------------------------------------------------
`default_nettype none

module two_wire_handshake_byte_transfer_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // write_byte[7:0], clock_in[8], data_in[9], zero fill
    input  wire logic [twhbt_pkg::IN_DATA_W-1:0]     s_tdata,
    // kind[1:0]
    input  wire logic [twhbt_pkg::IN_USER_W-1:0]     s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // atn_out[0], data_out[1], read_result[9:2], byte_done[10], busy_res[11], zero fill
    output logic [twhbt_pkg::OUT_DATA_W-1:0]         m_tdata
);
    import twhbt_pkg::*;

    logic  fr_valid;
    logic  fr_ready;
    item_t fr_item;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    twhbt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (fr_valid),
        .item       (fr_item),
        .item_ready (fr_ready)
    );

    twhbt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_item  (fr_item),
        .push_ready (fr_ready),
        .pop_valid  (q_valid),
        .pop_item   (q_item),
        .pop_ready  (q_ready)
    );

    twhbt_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (q_valid),
        .item       (q_item),
        .item_ready (q_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

// File: tb/twhbt_link_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// twhbt_link_checker
// Follows both stream channels of the two-wire byte engine. Every accepted
// line sample is run through a cycle-free copy of the host engine (half-step
// counter, shift register, attention and data drives) to form the expected
// result word. Accepted result words are compared field by field, in order.
// ----------------------------------------------------------------------------

module twhbt_link_checker
    import twhbt_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic [IN_USER_W-1:0]  s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    output int                         fail_count,
    output int                         awaited
);

    logic [3:0] half_cnt;
    logic [7:0] bit_shift;
    logic       writing;
    logic       engaged;
    logic       atn_drive;
    logic       data_drive;

    result_t    link_results_q[$];
    int         errs = 0;

    task advance_link_engine(input logic [1:0] kind, input logic [7:0] tx_byte,
                             input logic clk_lvl, input logic din_lvl,
                             output result_t res);
        logic       finished;
        logic [7:0] rx_byte;
        begin
            finished = 1'b0;
            rx_byte  = 8'h00;
            if (engaged) begin
                // even half-steps wait for clock released, odd ones for asserted
                if (clk_lvl == half_cnt[0]) begin
                    half_cnt = half_cnt + 4'd1;
                    if (!writing) begin
                        if (half_cnt <= LAST_SAMPLE)
                            bit_shift = (bit_shift >> 1) | (din_lvl ? SAMPLE_BIT : 8'h00);
                        if (half_cnt >= READ_STEPS) begin
                            engaged   = 1'b0;
                            finished  = 1'b1;
                            rx_byte   = bit_shift;
                            atn_drive = 1'b1;
                        end else begin
                            atn_drive = half_cnt[0];
                        end
                    end else begin
                        if (half_cnt >= WRITE_STEPS) begin
                            engaged    = 1'b0;
                            finished   = 1'b1;
                            data_drive = 1'b0;
                            atn_drive  = 1'b1;
                        end else begin
                            data_drive = bit_shift[0];
                            bit_shift  = bit_shift >> 1;
                            atn_drive  = half_cnt[0];
                        end
                    end
                end
            end else if (kind == KIND_READ) begin
                engaged   = 1'b1;
                writing   = 1'b0;
                half_cnt  = 4'd0;
                bit_shift = 8'h00;
                atn_drive = 1'b0;
            end else if (kind == KIND_WRITE) begin
                engaged    = 1'b1;
                writing    = 1'b1;
                half_cnt   = 4'd0;
                data_drive = tx_byte[0];
                bit_shift  = tx_byte >> 1;
                atn_drive  = 1'b0;
            end
            res.atn_out     = atn_drive;
            res.data_out    = data_drive;
            res.read_result = rx_byte;
            res.byte_done   = finished;
            res.busy_res    = engaged;
        end
    endtask

    task report_field(input string fname, input logic [7:0] want, input logic [7:0] got);
        begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
            errs++;
        end
    endtask

    task compare_result(input logic [OUT_DATA_W-1:0] got_word);
        result_t want;
        result_t got;
        begin
            if (link_results_q.size() == 0) begin
                $display("%0t ns: unexpected result transfer, expected none actual %0h",
                         $time, got_word);
                errs++;
            end else begin
                want = link_results_q.pop_front();
                got  = got_word[11:0];
                if (got.atn_out !== want.atn_out)
                    report_field("atn_out", 8'(want.atn_out), 8'(got.atn_out));
                if (got.data_out !== want.data_out)
                    report_field("data_out", 8'(want.data_out), 8'(got.data_out));
                if (got.read_result !== want.read_result)
                    report_field("read_result", want.read_result, got.read_result);
                if (got.byte_done !== want.byte_done)
                    report_field("byte_done", 8'(want.byte_done), 8'(got.byte_done));
                if (got.busy_res !== want.busy_res)
                    report_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                if (got_word[OUT_DATA_W-1:12] !== '0)
                    report_field("zero fill", 8'h00, 8'(got_word[OUT_DATA_W-1:12]));
            end
        end
    endtask

    always @(posedge aclk) begin : monitor
        result_t res;
        if (!aresetn) begin
            half_cnt   = 4'd0;
            bit_shift  = 8'h00;
            writing    = 1'b0;
            engaged    = 1'b0;
            atn_drive  = 1'b1;
            data_drive = 1'b0;
            link_results_q.delete();
        end else begin
            if (m_tvalid && m_tready)
                compare_result(m_tdata);
            if (s_tvalid && s_tready) begin
                advance_link_engine(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[9], res);
                link_results_q.push_back(res);
            end
        end
        fail_count <= errs;
        awaited    <= link_results_q.size();
    end

    final begin
        if (link_results_q.size() != 0)
            $display("%0t ns: %0d result transfers still outstanding",
                     $time, link_results_q.size());
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the two-wire byte engine: directed samples, a write and a read,
// then random well-formed byte transfers with line stalls, idle noise and
// abandoned transfers recovered by a toggling clock. Both channels pause at
// random; the checker beside the engine does all comparison.
// ----------------------------------------------------------------------------

module tb;
    import twhbt_pkg::*;

    localparam int         ITEM_TARGET = 450;
    localparam int         STALL_LIMIT = 2000;
    localparam int         TAIL_CYCLES = 12;
    localparam int         FLUSH_ITEMS = 12;
    localparam int         ANY_KIND    = -1;
    localparam logic [1:0] KIND_SPARE  = 2'd3;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [IN_USER_W-1:0]  s_tuser  = KIND_SAMPLE;
    logic                  m_tready = 1'b0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire [OUT_DATA_W-1:0]  m_tdata;

    int fail_count;
    int awaited;
    int items_sent   = 0;
    int stall_cycles = 0;
    bit steady       = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    two_wire_handshake_byte_transfer_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    twhbt_link_checker u_link_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .awaited    (awaited)
    );

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function logic [1:0] busy_pick(input int busy_kind);
        if (busy_kind < 0)
            return 2'($urandom_range(0, 3));
        return busy_kind[1:0];
    endfunction

    // entered and left at a falling edge
    task send_item(input logic [1:0] kind, input logic [7:0] tx_byte,
                   input logic clk_lvl, input logic din_lvl);
        int gap;
        begin
            gap = pick_gap();
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= kind;
            s_tdata  <= {6'b0, din_lvl, clk_lvl, tx_byte};
            do @(posedge aclk); while (!s_tready);
            items_sent++;
            @(negedge aclk);
        end
    endtask

    // start on an idle engine, then answer every half-step, with stalls
    task run_transfer(input logic [1:0] op, input logic [7:0] tx_byte,
                      input logic [9:0] rx_bits, input int stall_pct, input int busy_kind);
        int   steps;
        int   i;
        logic want;
        begin
            steps = (op == KIND_WRITE) ? WRITE_STEPS : READ_STEPS;
            send_item(op, tx_byte, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            for (i = 0; i < steps; i++) begin
                want = (i % 2) != 0;
                while ($urandom_range(0, 99) < stall_pct)
                    send_item(busy_pick(busy_kind), 8'($urandom), !want,
                              1'($urandom_range(0, 1)));
                send_item(busy_pick(busy_kind), 8'($urandom), want, rx_bits[i]);
            end
        end
    endtask

    // a toggling clock completes any transfer in progress
    task flush_link();
        logic clk_lvl;
        begin
            clk_lvl = 1'($urandom_range(0, 1));
            repeat (FLUSH_ITEMS) begin
                send_item(KIND_SAMPLE, 8'($urandom), clk_lvl, 1'($urandom_range(0, 1)));
                clk_lvl = !clk_lvl;
            end
        end
    endtask

    initial begin : sink_pace
        int len;
        @(negedge aclk);
        forever begin
            m_tready <= 1'b1;
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 5);
            repeat (len) @(negedge aclk);
            len = pick_gap();
            if (len > 0) begin
                m_tready <= 1'b0;
                repeat (len) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : source
        int   r;
        logic [1:0] op;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // idle samples, spare kind, write and read with starts while busy
        send_item(KIND_SAMPLE, 8'h00, 1'b0, 1'b0);
        send_item(KIND_SPARE, 8'hFF, 1'b1, 1'b1);
        run_transfer(KIND_WRITE, 8'h81, 10'h000, 20, KIND_READ);
        run_transfer(KIND_READ, 8'h00, 10'h2A9, 20, KIND_WRITE);

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 5) == 0)
                steady = ($urandom_range(0, 2) == 0);
            r  = $urandom_range(0, 99);
            op = $urandom_range(0, 1) ? KIND_WRITE : KIND_READ;
            if (r < 75) begin
                run_transfer(op, pick_byte(), {2'($urandom_range(0, 3)), pick_byte()},
                             ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 45),
                             ANY_KIND);
            end else if (r < 90) begin
                repeat ($urandom_range(1, 4))
                    send_item($urandom_range(0, 1) ? KIND_SAMPLE : KIND_SPARE, 8'($urandom),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                send_item(op, 8'($urandom), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                repeat ($urandom_range(1, 8))
                    send_item(2'($urandom_range(0, 3)), 8'($urandom),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                flush_link();
            end
        end
        s_tvalid <= 1'b0;

        while (awaited != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
